// ===== src/cbc_pkg.sv =====
// ---------------------------------------------------------------------------
// cbc_pkg
// Shared widths, register and step codes, control word types and the
// microcode table of the cell balance controller.
// ---------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

    localparam int NUM_CELL_INPUTS = 4;
    localparam int MAX_CELLS_DEF   = 4;

    localparam int CELL_W  = 16;
    localparam int CELLS_W = 3;
    localparam int SMAX_W  = 4;
    localparam int SCALE_W = 12;
    localparam int FRAC_W  = 8;
    localparam int DIVD_W  = SMAX_W + FRAC_W + CELL_W;
    localparam int QCNT_W  = $clog2(DIVD_W);
    localparam int PROD_W  = CELL_W + SCALE_W;
    localparam int IDX_W   = $clog2(NUM_CELL_INPUTS);
    localparam int MASK_W  = NUM_CELL_INPUTS;
    localparam int CIDX_W  = 3;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 12'd256;
    localparam logic [SCALE_W-1:0] SCALE_SAT = 12'd4095;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_CELLS = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SMAX  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_VBAL  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_VCHG  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_DELTA = 3'd4;
    localparam logic [CIDX_W-1:0] REG_HYST  = 3'd5;
    localparam logic [CIDX_W-1:0] REG_OVP   = 3'd6;

    // program steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SETUP  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DIV    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CLAMP  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MUL_ON = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MUL_HY = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FLAG   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_MASK   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OUT    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_OUT;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 4'd2;
    localparam logic [OP_W-1:0] OP_SCAN   = 4'd3;
    localparam logic [OP_W-1:0] OP_SETUP  = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV    = 4'd5;
    localparam logic [OP_W-1:0] OP_CLAMP  = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_ON = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_HY = 4'd8;
    localparam logic [OP_W-1:0] OP_FLAG   = 4'd9;
    localparam logic [OP_W-1:0] OP_MASK   = 4'd10;
    localparam logic [OP_W-1:0] OP_OUT    = 4'd11;

    // jump conditions: jump to target when true, else advance
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEXT      = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] C_NO_ACCEPT = 3'd2;
    localparam logic [COND_W-1:0] C_OFF       = 3'd3;
    localparam logic [COND_W-1:0] C_IDX_MORE  = 3'd4;
    localparam logic [COND_W-1:0] C_S_ONE     = 3'd5;
    localparam logic [COND_W-1:0] C_DIV_MORE  = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_BUSY  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } cbc_ctrl_t;

    typedef struct packed {
        logic accept;
        logic off;
        logic s_one;
        logic idx_more;
        logic div_more;
        logic out_busy;
    } cbc_status_t;

    typedef struct packed {
        logic [CELLS_W-1:0] cells;
        logic [SMAX_W-1:0]  smax;
        logic [CELL_W-1:0]  vbal;
        logic [CELL_W-1:0]  vchg;
        logic [CELL_W-1:0]  delta;
        logic [CELL_W-1:0]  hyst;
        logic [CELL_W-1:0]  ovp;
    } cbc_cfg_t;

    function automatic cbc_ctrl_t cbc_rom(input logic [STEP_W-1:0] step);
        cbc_ctrl_t w;
        unique case (step)
            STEP_WAIT:   w = '{op: OP_LOAD,   cond: C_NO_ACCEPT, target: STEP_WAIT};
            STEP_CHECK:  w = '{op: OP_CHECK,  cond: C_OFF,       target: STEP_OUT};
            STEP_SCAN:   w = '{op: OP_SCAN,   cond: C_IDX_MORE,  target: STEP_SCAN};
            STEP_SETUP:  w = '{op: OP_SETUP,  cond: C_S_ONE,     target: STEP_MUL_ON};
            STEP_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE,  target: STEP_DIV};
            STEP_CLAMP:  w = '{op: OP_CLAMP,  cond: C_NEXT,      target: STEP_WAIT};
            STEP_MUL_ON: w = '{op: OP_MUL_ON, cond: C_NEXT,      target: STEP_WAIT};
            STEP_MUL_HY: w = '{op: OP_MUL_HY, cond: C_NEXT,      target: STEP_WAIT};
            STEP_FLAG:   w = '{op: OP_FLAG,   cond: C_NEXT,      target: STEP_WAIT};
            STEP_MASK:   w = '{op: OP_MASK,   cond: C_IDX_MORE,  target: STEP_MASK};
            STEP_OUT:    w = '{op: OP_OUT,    cond: C_OUT_BUSY,  target: STEP_OUT};
            default:     w = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/cbc_seq.sv =====
// ---------------------------------------------------------------------------
// cbc_seq
// Step counter and microcode table; resolves conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module cbc_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cbc_pkg::cbc_status_t        status,
    output cbc_pkg::cbc_ctrl_t               ctrl,
    output logic [cbc_pkg::STEP_W-1:0]       step
);
    import cbc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              take;

    assign ctrl = cbc_rom(step_reg);
    assign step = step_reg;

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ACCEPT: take = !status.accept;
            C_OFF:       take = status.off;
            C_IDX_MORE:  take = status.idx_more;
            C_S_ONE:     take = status.s_one;
            C_DIV_MORE:  take = status.div_more;
            C_OUT_BUSY:  take = status.out_busy;
        endcase

        if (take)
        begin
            step_next = ctrl.target;
        end
        else if (step_reg == STEP_LAST)
        begin
            step_next = STEP_WAIT;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/cbc_dp.sv =====
// ---------------------------------------------------------------------------
// cbc_dp
// Datapath: cell scan, restoring divider, threshold products, hysteresis
// flag, bleed mask and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cbc_dp #(
    parameter int MAX_CELLS = cbc_pkg::MAX_CELLS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cbc_pkg::cbc_cfg_t             cfg,
    input  wire logic [cbc_pkg::OP_W-1:0]      op,
    input  wire logic                          accept,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cell_one_mv,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cell_two_mv,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cell_three_mv,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cell_four_mv,
    input  wire logic                          port_present,
    input  wire logic                          main_present,
    input  wire logic                          fault_present,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [cbc_pkg::MASK_W-1:0]         discharge_drive,
    output logic                               balancing_active,
    output cbc_pkg::cbc_status_t               status
);
    import cbc_pkg::*;

    localparam int CELL_LIM = (MAX_CELLS < NUM_CELL_INPUTS) ? MAX_CELLS : NUM_CELL_INPUTS;
    localparam logic [CELLS_W-1:0] CELL_LIM_V = CELLS_W'(CELL_LIM);

    // control state
    logic              flag_reg,  flag_next;
    logic [MASK_W-1:0] mask_reg,  mask_next;
    logic              ovld_reg,  ovld_next;

    // payload
    logic [CELL_W-1:0] cell_reg [NUM_CELL_INPUTS];
    logic [CELL_W-1:0] cell_next [NUM_CELL_INPUTS];
    logic              off_reg,   off_next;
    logic              main_reg,  main_next;
    logic [CELL_W-1:0] vmin_reg,  vmin_next;
    logic [CELL_W-1:0] vmax_reg,  vmax_next;
    logic [IDX_W-1:0]  idx_reg,   idx_next;
    logic [CELL_W-1:0] den_reg,   den_next;
    logic [CELL_W-1:0] rem_reg,   rem_next;
    logic [DIVD_W-1:0] dq_reg,    dq_next;
    logic [QCNT_W-1:0] cnt_reg,   cnt_next;
    logic [SCALE_W-1:0] s_reg,    s_next;
    logic [PROD_W-1:0] thr_on_reg, thr_on_next;
    logic [PROD_W-1:0] thr_hy_reg, thr_hy_next;
    logic [MASK_W-1:0] drive_reg, drive_next;
    logic              act_reg,   act_next;

    logic [CELLS_W-1:0] n_use;
    logic [CELLS_W-1:0] n_scan;
    logic [CELL_W-1:0]  cur;
    logic [CELL_W-1:0]  num;
    logic [CELL_W:0]    shifted;
    logic [CELL_W:0]    trial;
    logic [PROD_W-1:0]  spread;
    logic [PROD_W-1:0]  excess;
    logic               out_busy;

    assign n_use    = (cfg.cells > CELL_LIM_V) ? CELL_LIM_V : cfg.cells;
    assign n_scan   = (n_use == '0) ? CELLS_W'(1) : n_use;
    assign cur      = cell_reg[idx_reg];
    assign num      = (vmax_reg < cfg.vchg) ? (cfg.vchg - vmax_reg) : '0;
    assign shifted  = {rem_reg, dq_reg[DIVD_W-1]};
    assign trial    = shifted - {1'b0, den_reg};
    assign spread   = PROD_W'({vmax_reg - vmin_reg, {FRAC_W{1'b0}}});
    assign excess   = PROD_W'({cur - vmin_reg, {FRAC_W{1'b0}}});
    assign out_busy = ovld_reg && out_stall;

    assign status.accept   = accept;
    assign status.off      = off_reg;
    assign status.s_one    = !main_reg || (cfg.vchg <= cfg.vbal);
    assign status.idx_more = (idx_reg != IDX_W'(NUM_CELL_INPUTS - 1));
    assign status.div_more = (cnt_reg != QCNT_W'(DIVD_W - 1));
    assign status.out_busy = out_busy;

    assign out_valid        = ovld_reg;
    assign discharge_drive  = drive_reg;
    assign balancing_active = act_reg;

    always_comb
    begin
        flag_next   = flag_reg;
        mask_next   = mask_reg;
        ovld_next   = ovld_reg && out_stall;
        cell_next   = cell_reg;
        off_next    = off_reg;
        main_next   = main_reg;
        vmin_next   = vmin_reg;
        vmax_next   = vmax_reg;
        idx_next    = idx_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        dq_next     = dq_reg;
        cnt_next    = cnt_reg;
        s_next      = s_reg;
        thr_on_next = thr_on_reg;
        thr_hy_next = thr_hy_reg;
        drive_next  = drive_reg;
        act_next    = act_reg;

        unique case (op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    cell_next[0] = cell_one_mv;
                    cell_next[1] = cell_two_mv;
                    cell_next[2] = cell_three_mv;
                    cell_next[3] = cell_four_mv;
                    off_next     = !port_present || fault_present;
                    main_next    = main_present;
                    vmin_next    = cell_one_mv;
                    vmax_next    = cell_one_mv;
                    idx_next     = IDX_W'(1);
                end
            end
            OP_CHECK:
            begin
                if (off_reg)
                begin
                    flag_next = 1'b0;
                end
            end
            OP_SCAN:
            begin
                if (CELLS_W'(idx_reg) < n_scan)
                begin
                    if (cur < vmin_reg)
                    begin
                        vmin_next = cur;
                    end
                    if (cur > vmax_reg)
                    begin
                        vmax_next = cur;
                    end
                end
                idx_next = idx_reg + 1'b1;
            end
            OP_SETUP:
            begin
                den_next = cfg.vchg - cfg.vbal;
                dq_next  = (DIVD_W'(cfg.smax) * DIVD_W'(num)) << FRAC_W;
                rem_next = '0;
                cnt_next = '0;
                s_next   = SCALE_ONE;
                idx_next = '0;
            end
            OP_DIV:
            begin
                if (!trial[CELL_W])
                begin
                    rem_next = trial[CELL_W-1:0];
                    dq_next  = {dq_reg[DIVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[CELL_W-1:0];
                    dq_next  = {dq_reg[DIVD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            OP_CLAMP:
            begin
                if (dq_reg < DIVD_W'(SCALE_ONE))
                begin
                    s_next = SCALE_ONE;
                end
                else if (dq_reg > DIVD_W'(SCALE_SAT))
                begin
                    s_next = SCALE_SAT;
                end
                else
                begin
                    s_next = dq_reg[SCALE_W-1:0];
                end
            end
            OP_MUL_ON:
            begin
                thr_on_next = PROD_W'(cfg.delta) * PROD_W'(s_reg);
            end
            OP_MUL_HY:
            begin
                thr_hy_next = PROD_W'(cfg.hyst) * PROD_W'(s_reg);
            end
            OP_FLAG:
            begin
                if (spread >= thr_on_reg && vmin_reg > cfg.vbal && !flag_reg)
                begin
                    flag_next = 1'b1;
                end
                else if ((spread < thr_hy_reg && flag_reg) || vmin_reg < cfg.vbal)
                begin
                    flag_next = 1'b0;
                end
            end
            OP_MASK:
            begin
                if (CELLS_W'(idx_reg) < n_use)
                begin
                    if (cur >= cfg.ovp)
                    begin
                        mask_next[idx_reg] = 1'b1;
                    end
                    else if (flag_reg && excess >= thr_hy_reg)
                    begin
                        mask_next[idx_reg] = 1'b1;
                    end
                    else
                    begin
                        mask_next[idx_reg] = 1'b0;
                    end
                end
                idx_next = idx_reg + 1'b1;
            end
            OP_OUT:
            begin
                if (!out_busy)
                begin
                    ovld_next  = 1'b1;
                    drive_next = off_reg ? '0 : mask_reg;
                    act_next   = off_reg ? 1'b0 : flag_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            mask_reg <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
            mask_reg <= mask_next;
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        off_reg    <= off_next;
        main_reg   <= main_next;
        vmin_reg   <= vmin_next;
        vmax_reg   <= vmax_next;
        idx_reg    <= idx_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        cnt_reg    <= cnt_next;
        s_reg      <= s_next;
        thr_on_reg <= thr_on_next;
        thr_hy_reg <= thr_hy_next;
        drive_reg  <= drive_next;
        act_reg    <= act_next;
    end

endmodule

`default_nettype wire

// ===== src/cell_balance_controller_top.sv =====
// ---------------------------------------------------------------------------
// cell_balance_controller_top
// Passive cell balancing controller with hysteresis, microcoded.
// ---------------------------------------------------------------------------
// One measurement round is taken per input transfer: four cell voltages in
// mV plus balance-port, main-connector and fault flags. The block finds the
// lowest and highest of the cells in use, forms a Q4.8 scale factor
// smax*(vchg-vmax)/(vchg-vbal) clamped to [1.0, 4095/256], switches the
// balancing enable with scaled on/off spread thresholds and updates one
// bleed bit per cell. Each round yields exactly one result transfer. A
// new round is taken only once the sequencer is back at its wait step; the
// restoring divide (one quotient bit per cycle) dominates, the cell scan
// visits each cell input after the first and the mask update every cell
// input. When the scale factor is fixed at 1.0 (main connector off or vchg
// not above vbal) the divide is skipped; a round with no port or a fault
// goes straight from the check step to the output step. The output register
// lets the sequencer finish the next round while a result is still held by
// a stalled receiver; the sequencer only waits at its output step when the
// previous result is still waiting. Configuration writes are always ready
// and must only be issued while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module cell_balance_controller_top #(
    parameter int MAX_CELLS = cbc_pkg::MAX_CELLS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // measurement round channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cell_one_mv,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cell_two_mv,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cell_three_mv,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cell_four_mv,
    input  wire logic                          port_present,
    input  wire logic                          main_present,
    input  wire logic                          fault_present,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [cbc_pkg::MASK_W-1:0]         discharge_drive,
    output logic                               balancing_active,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cbc_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [cbc_pkg::CELL_W-1:0]    cfg_data
);
    import cbc_pkg::*;

    cbc_cfg_t          cfg_reg;
    cbc_cfg_t          cfg_next;
    cbc_ctrl_t         ctrl;
    cbc_status_t       status;
    logic [STEP_W-1:0] step;
    logic              in_accept;
    logic              cfg_write;

    // Take a new round only while the sequencer sits at its wait step.
    assign in_stall  = (step != STEP_WAIT);
    assign in_accept = in_valid && !in_stall;

    // Register writes go straight into the configuration register, so the port never holds off.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Decode the register index; drop writes beyond the register list.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CELLS: cfg_next.cells = cfg_data[CELLS_W-1:0];
                REG_SMAX:  cfg_next.smax  = cfg_data[SMAX_W-1:0];
                REG_VBAL:  cfg_next.vbal  = cfg_data;
                REG_VCHG:  cfg_next.vchg  = cfg_data;
                REG_DELTA: cfg_next.delta = cfg_data;
                REG_HYST:  cfg_next.hyst  = cfg_data;
                REG_OVP:   cfg_next.ovp   = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cells <= CELLS_W'(4);
            cfg_reg.smax  <= SMAX_W'(4);
            cfg_reg.vbal  <= CELL_W'(3000);
            cfg_reg.vchg  <= CELL_W'(4150);
            cfg_reg.delta <= CELL_W'(50);
            cfg_reg.hyst  <= CELL_W'(20);
            cfg_reg.ovp   <= CELL_W'(4250);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: step counter and control word table.
    cbc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .step   (step)
    );

    // Datapath driven by the current control word.
    cbc_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .op               (ctrl.op),
        .accept           (in_accept),
        .cell_one_mv      (cell_one_mv),
        .cell_two_mv      (cell_two_mv),
        .cell_three_mv    (cell_three_mv),
        .cell_four_mv     (cell_four_mv),
        .port_present     (port_present),
        .main_present     (main_present),
        .fault_present    (fault_present),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .discharge_drive  (discharge_drive),
        .balancing_active (balancing_active),
        .status           (status)
    );

    // An accepted round always advances to the service check.
    a_accept_advances: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (step == STEP_CHECK))
        else $error("accepted round did not advance to check step");

    // A result is only raised from the output step.
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step == STEP_OUT))
        else $error("result raised outside output step");

    // Leaving the output step with room loads the output register.
    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (step == STEP_OUT && !(out_valid && out_stall)) |=> out_valid)
        else $error("output step left without loading a result");

endmodule

`default_nettype wire
